// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the ETC1 block decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/etc1_pkg.sv
// Types, constants and pixel arithmetic for the ETC1 block decoder.
package etc1_pkg;

    localparam int DEF_MAX_TILES = 128;

    typedef enum logic [1:0] {
        CFG_HAS_ALPHA    = 2'd0,
        CFG_PREMULTIPLY  = 2'd1,
        CFG_WIDTH_TILES  = 2'd2,
        CFG_HEIGHT_TILES = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] alpha_word;
        logic [15:0] index_low_bits;
        logic [15:0] index_sign_bits;
        logic [31:0] color_word;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic       last_of_block;
        logic       last_of_image;
    } t_out_item;

    function automatic logic [7:0] mod_val(input logic [2:0] tbl, input logic col);
        logic [7:0] lo;
        logic [7:0] hi;
        case (tbl)
            3'd0: begin lo = 8'd2;  hi = 8'd8;   end
            3'd1: begin lo = 8'd5;  hi = 8'd17;  end
            3'd2: begin lo = 8'd9;  hi = 8'd29;  end
            3'd3: begin lo = 8'd13; hi = 8'd42;  end
            3'd4: begin lo = 8'd18; hi = 8'd60;  end
            3'd5: begin lo = 8'd24; hi = 8'd80;  end
            3'd6: begin lo = 8'd33; hi = 8'd106; end
            default: begin lo = 8'd47; hi = 8'd183; end
        endcase
        return col ? hi : lo;
    endfunction

    function automatic logic [7:0] base_chan(input logic [7:0] chan_byte,
                                             input logic second, input logic diff);
        logic [4:0] b5;
        logic [3:0] n;
        b5 = chan_byte[7:3];
        n  = second ? chan_byte[3:0] : chan_byte[7:4];
        if (diff) begin
            if (second) begin
                b5 = b5 + {chan_byte[2], chan_byte[2], chan_byte[2:0]};
            end
            return {b5, b5[4:2]};
        end
        return {n, n};
    endfunction

    function automatic logic [7:0] apply_mod(input logic [7:0] c, input logic [7:0] m,
                                             input logic neg);
        logic [8:0] sum;
        sum = {1'b0, c} + {1'b0, m};
        if (neg) begin
            return (c >= m) ? (c - m) : 8'd0;
        end
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

    // Exact floor(x / 255) for any product of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

// File: rtl/core/etc1_a4_tiled_block_decode_unit.sv
// Top level of the ETC1 block decoder with 4-bit alpha and 8x8 tile walking.
// A block transfer decodes to sixteen pixels, column-major, one per cycle unless stalled.
// A transfer goes to the block register, then its first pixel to the output register.
// Block throughput is set by the single-pixel output register.
// The next block is taken in the cycle its predecessor's last pixel is produced.
// Synchronous active-low reset clears valids and tile counters and loads register defaults.
module etc1_a4_tiled_block_decode_unit #(
    parameter int MAX_TILES = etc1_pkg::DEF_MAX_TILES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  etc1_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output etc1_pkg::t_out_item o_out_data
);
    import etc1_pkg::*;
    `include "assert_macros.svh"

    localparam int TILE_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam logic [9:0] MAX_T = 10'(MAX_TILES);

    logic              r_has_alpha;
    logic              r_premultiply;
    logic [7:0]        r_width_tiles;
    logic [7:0]        r_height_tiles;

    logic [1:0]        r_sub_block;
    logic [TILE_W-1:0] r_tile_col;
    logic [TILE_W-1:0] r_tile_row;

    t_in_item          r_blk;
    logic              r_blk_vld;
    logic [3:0]        r_k;
    logic [9:0]        r_bx;
    logic [9:0]        r_by;
    logic              r_last_img;

    t_out_item         r_out;
    logic              r_out_vld;

    logic              out_ld;
    logic              adv;
    logic              in_acc;
    logic [9:0]        wt;
    logic [9:0]        ht;
    logic              last_col;
    logic              last_row;
    logic [12:0]       bx_full;
    logic [12:0]       by_full;
    logic [1:0]        n_sub_block;
    logic [TILE_W-1:0] n_tile_col;
    logic [TILE_W-1:0] n_tile_row;
    t_out_item         n_pix;

    assign out_ld     = !r_out_vld || !i_out_stall;
    assign adv        = r_blk_vld && out_ld;
    assign o_in_stall = r_blk_vld && !(adv && (r_k == 4'd15));
    assign in_acc     = i_in_valid && !o_in_stall;

    // Tile position of the block being taken in.
    always_comb begin
        wt = (r_width_tiles == 8'd0) ? 10'd1 :
             ((10'(r_width_tiles) > MAX_T) ? MAX_T : 10'(r_width_tiles));
        ht = (r_height_tiles == 8'd0) ? 10'd1 :
             ((10'(r_height_tiles) > MAX_T) ? MAX_T : 10'(r_height_tiles));
        last_col = (10'(r_tile_col) + 10'd1) >= wt;
        last_row = (10'(r_tile_row) + 10'd1) >= ht;
        bx_full  = 13'({r_tile_col, r_sub_block[0], 2'b00});
        by_full  = 13'({r_tile_row, r_sub_block[1], 2'b00});
        n_sub_block = r_sub_block + 2'd1;
        n_tile_col  = r_tile_col;
        n_tile_row  = r_tile_row;
        if (r_sub_block == 2'd3) begin
            if (!last_col) begin
                n_tile_col = r_tile_col + TILE_W'(1);
            end else begin
                n_tile_col = '0;
                n_tile_row = last_row ? '0 : (r_tile_row + TILE_W'(1));
            end
        end
    end

    // Decode of the current pixel of the held block.
    always_comb begin
        logic [1:0]  sx;
        logic [1:0]  sy;
        logic        second;
        logic        diff;
        logic [2:0]  tbl;
        logic [7:0]  m;
        logic        neg;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [3:0]  nib;
        logic [7:0]  a;
        sx     = r_k[3:2];
        sy     = r_k[1:0];
        second = r_blk.color_word[0] ? sy[1] : sx[1];
        diff   = r_blk.color_word[1];
        tbl    = second ? r_blk.color_word[4:2] : r_blk.color_word[7:5];
        m      = mod_val(tbl, r_blk.index_low_bits[r_k]);
        neg    = r_blk.index_sign_bits[r_k];
        r = apply_mod(base_chan(r_blk.color_word[31:24], second, diff), m, neg);
        g = apply_mod(base_chan(r_blk.color_word[23:16], second, diff), m, neg);
        b = apply_mod(base_chan(r_blk.color_word[15:8], second, diff), m, neg);
        nib = r_blk.alpha_word[{r_k, 2'b00} +: 4];
        a   = r_has_alpha ? {nib, nib} : 8'hFF;
        if (r_has_alpha && r_premultiply) begin
            r = div255(16'(r) * 16'(a));
            g = div255(16'(g) * 16'(a));
            b = div255(16'(b) * 16'(a));
        end
        n_pix.red           = r;
        n_pix.green         = g;
        n_pix.blue          = b;
        n_pix.alpha         = a;
        n_pix.pixel_x       = r_bx + 10'(sx);
        n_pix.pixel_y       = r_by + 10'(sy);
        n_pix.last_of_block = (r_k == 4'd15);
        n_pix.last_of_image = (r_k == 4'd15) && r_last_img;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_alpha    <= 1'b0;
            r_premultiply  <= 1'b1;
            r_width_tiles  <= 8'd1;
            r_height_tiles <= 8'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HAS_ALPHA:    r_has_alpha    <= i_cfg_data[0];
                CFG_PREMULTIPLY:  r_premultiply  <= i_cfg_data[0];
                CFG_WIDTH_TILES:  r_width_tiles  <= i_cfg_data;
                CFG_HEIGHT_TILES: r_height_tiles <= i_cfg_data;
                default:          r_has_alpha    <= r_has_alpha;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_block <= 2'd0;
            r_tile_col  <= '0;
            r_tile_row  <= '0;
            r_blk_vld   <= 1'b0;
            r_k         <= 4'd0;
        end else begin
            if (adv) begin
                r_k <= r_k + 4'd1;
            end
            if (in_acc) begin
                r_blk_vld   <= 1'b1;
                r_sub_block <= n_sub_block;
                r_tile_col  <= n_tile_col;
                r_tile_row  <= n_tile_row;
            end else if (adv && (r_k == 4'd15)) begin
                r_blk_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_blk      <= i_in_data;
            r_bx       <= bx_full[9:0];
            r_by       <= by_full[9:0];
            r_last_img <= last_col && last_row && (r_sub_block == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ld) begin
            r_out_vld <= r_blk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_pix;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `ASSERT_RST(a_img_ends_block, i_clk, i_rst_n, (o_out_valid && o_out_data.last_of_image) |-> o_out_data.last_of_block, "last_of_image without last_of_block")
    `ASSERT_RST(a_k_needs_block, i_clk, i_rst_n, (r_k != 4'd0) |-> r_blk_vld, "pixel count runs without a held block")
    `ASSERT_RST(a_k_wraps, i_clk, i_rst_n, (adv && (r_k == 4'd15)) |=> (r_k == 4'd0), "pixel count does not restart after the last pixel")
    `ASSERT_RST(a_col_range, i_clk, i_rst_n, 10'(r_tile_col) < MAX_T, "tile column beyond the largest image")
    `ASSERT_RST(a_row_range, i_clk, i_rst_n, 10'(r_tile_row) < MAX_T, "tile row beyond the largest image")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the ETC1 block decoder: directed, random and back-pressure tests.
module tb_top;
    import etc1_pkg::*;

    localparam int TILE_LIMIT     = DEF_MAX_TILES;
    localparam int DRAIN_CYCLES   = 48;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    t_cfg_idx  cfg_idx   = CFG_HAS_ALPHA;
    logic [7:0] cfg_data = 8'd0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    bit         has_alpha_q = 1'b0;
    bit         premult_q   = 1'b1;
    logic [7:0] width_q     = 8'd1;
    logic [7:0] height_q    = 8'd1;

    int unsigned quad   = 0;
    int unsigned tile_x = 0;
    int unsigned tile_y = 0;

    t_out_item expected_pixels[$];
    int error_count  = 0;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    etc1_a4_tiled_block_decode_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned tiles_used(logic [7:0] v);
        if (v == 8'd0) return 1;
        if (int'(v) > TILE_LIMIT) return TILE_LIMIT;
        return v;
    endfunction

    function automatic int unsigned channel_base(logic [7:0] byt, bit second, bit diff);
        int unsigned b5;
        int delta;
        if (diff) begin
            b5 = byt[7:3];
            if (second) begin
                delta = byt[2] ? int'(byt[2:0]) - 8 : int'(byt[2:0]);
                b5 = (b5 + delta) & 31;
            end
            return (b5 << 3) | (b5 >> 2);
        end
        return second ? int'(byt[3:0]) * 17 : int'(byt[7:4]) * 17;
    endfunction

    function automatic int unsigned modifier(int unsigned tbl, bit far);
        case (tbl)
            0: return far ? 8 : 2;
            1: return far ? 17 : 5;
            2: return far ? 29 : 9;
            3: return far ? 42 : 13;
            4: return far ? 60 : 18;
            5: return far ? 80 : 24;
            6: return far ? 106 : 33;
            default: return far ? 183 : 47;
        endcase
    endfunction

    function automatic int unsigned shifted(int unsigned c, int unsigned m, bit neg);
        if (neg) return (c > m) ? c - m : 0;
        return (c + m > 255) ? 255 : c + m;
    endfunction

    function automatic void decode_block(t_in_item blk);
        int unsigned wt, ht, bx, by, col, row, tbl, m, a;
        int unsigned rgb[3];
        bit diff, flip, second, neg, last_col, last_row, last_img;
        t_out_item px;
        diff = blk.color_word[1];
        flip = blk.color_word[0];
        wt = tiles_used(width_q);
        ht = tiles_used(height_q);
        last_col = (tile_x + 1) >= wt;
        last_row = (tile_y + 1) >= ht;
        last_img = last_col && last_row && (quad == 3);
        bx = tile_x * 8 + (quad & 1) * 4;
        by = tile_y * 8 + (quad >> 1) * 4;
        for (int k = 0; k < 16; k++) begin
            col = k / 4;
            row = k % 4;
            second = (flip ? row : col) >= 2;
            tbl = second ? blk.color_word[4:2] : blk.color_word[7:5];
            m = modifier(tbl, blk.index_low_bits[k]);
            neg = blk.index_sign_bits[k];
            for (int ch = 0; ch < 3; ch++) begin
                rgb[ch] = shifted(channel_base(blk.color_word[31 - 8 * ch -: 8], second, diff),
                                  m, neg);
            end
            a = 255;
            if (has_alpha_q) begin
                a = int'(blk.alpha_word[4 * k +: 4]) * 17;
                if (premult_q) begin
                    for (int ch = 0; ch < 3; ch++) rgb[ch] = rgb[ch] * a / 255;
                end
            end
            px.red           = 8'(rgb[0]);
            px.green         = 8'(rgb[1]);
            px.blue          = 8'(rgb[2]);
            px.alpha         = 8'(a);
            px.pixel_x       = 10'(bx + col);
            px.pixel_y       = 10'(by + row);
            px.last_of_block = (k == 15);
            px.last_of_image = (k == 15) && last_img;
            expected_pixels.push_back(px);
        end
        if (quad < 3) begin
            quad++;
        end else begin
            quad = 0;
            if (!last_col) begin
                tile_x++;
            end else begin
                tile_x = 0;
                tile_y = last_row ? 0 : tile_y + 1;
            end
        end
    endfunction

    function automatic t_in_item make_block(logic [63:0] aw, logic [15:0] lo, logic [15:0] sg,
                                            logic [31:0] cw);
        t_in_item b;
        b.alpha_word      = aw;
        b.index_low_bits  = lo;
        b.index_sign_bits = sg;
        b.color_word      = cw;
        return b;
    endfunction

    function automatic t_in_item random_block();
        return make_block({$urandom, $urandom}, 16'($urandom), 16'($urandom), $urandom);
    endfunction

    function automatic logic [7:0] pick_tiles();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd128;
        if (r == 2) return 8'($urandom_range(129, 255));
        return 8'($urandom_range(1, 3));
    endfunction

    task automatic send_block(t_in_item blk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= blk;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        decode_block(blk);
    endtask

    task automatic wait_idle;
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_HAS_ALPHA:    has_alpha_q = val[0];
            CFG_PREMULTIPLY:  premult_q   = val[0];
            CFG_WIDTH_TILES:  width_q     = val;
            CFG_HEIGHT_TILES: height_q    = val;
            default: ;
        endcase
    endtask

    task automatic configure(bit alpha_on, bit premult_on, logic [7:0] w, logic [7:0] h);
        wait_idle;
        write_reg(CFG_HAS_ALPHA, {7'd0, alpha_on});
        write_reg(CFG_PREMULTIPLY, {7'd0, premult_on});
        write_reg(CFG_WIDTH_TILES, w);
        write_reg(CFG_HEIGHT_TILES, h);
    endtask

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    task automatic test_directed;
        logic [31:0] cw;
        configure(1'b0, 1'b1, 8'd1, 8'd1);
        send_block(make_block(64'h0, 16'h0000, 16'h0000, 32'h0000_0000));
        send_block(make_block('1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_block(make_block(64'h0, 16'hFFFF, 16'h0000, 32'hFFFF_FFFC));
        send_block(make_block(64'h0, 16'h00FF, 16'h0F0F, 32'hFBFB_FB02));
        send_block(make_block(64'h0, 16'hF00F, 16'hFFFF, 32'h0404_0403));
        for (int t = 0; t < 8; t++) begin
            cw = $urandom;
            cw[7:0] = {3'(t), 3'(7 - t), t[1], t[0]};
            send_block(make_block({$urandom, $urandom}, 16'hA5C3 ^ 16'(t), 16'h5A3C, cw));
        end
        configure(1'b1, 1'b1, 8'd1, 8'd1);
        send_block(make_block(64'h0, 16'($urandom), 16'($urandom), $urandom));
        send_block(make_block('1, 16'($urandom), 16'($urandom), $urandom));
        send_block(make_block(64'hFEDC_BA98_7654_3210, 16'($urandom), 16'($urandom), $urandom));
        configure(1'b1, 1'b0, 8'd1, 8'd1);
        send_block(make_block(64'h0123_4567_89AB_CDEF, 16'($urandom), 16'($urandom), $urandom));
        configure(1'b0, 1'b1, 8'd1, 8'd1);
        send_block(random_block());
        configure(1'b0, 1'b0, 8'd0, 8'd0);
        repeat (2) send_block(random_block());
        configure(1'b1, 1'b1, 8'd255, 8'd200);
        repeat (2) send_block(random_block());
    endtask

    task automatic test_random_traffic(int src_pct, int dst_pct);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        repeat (3) begin
            configure($urandom_range(0, 1), $urandom_range(0, 1), pick_tiles(), pick_tiles());
            repeat (10) send_block(random_block());
        end
    endtask

    task automatic test_output_hold;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        configure(1'b1, 1'b1, 8'd2, 8'd2);
        hold_req = 1'b1;
        repeat (8) send_block(random_block());
    endtask

    always @(posedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < dst_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("pixel transfer with no pending expectation: %p", out_data);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("red", want.red, out_data.red);
                check_field("green", want.green, out_data.green);
                check_field("blue", want.blue, out_data.blue);
                check_field("alpha", want.alpha, out_data.alpha);
                check_field("pixel_x", want.pixel_x, out_data.pixel_x);
                check_field("pixel_y", want.pixel_y, out_data.pixel_y);
                check_field("last_of_block", want.last_of_block, out_data.last_of_block);
                check_field("last_of_image", want.last_of_image, out_data.last_of_image);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed;
        test_random_traffic(18, 56);
        test_random_traffic(56, 18);
        test_random_traffic(0, 0);
        test_output_hold;
        wait_idle;
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
